FILE: src/elf_hash_bucket_index_defines.svh
// Assertion macros used by the ELF hash bucket index back end.
`ifndef ELF_HASH_BUCKET_INDEX_DEFINES_SVH
`define ELF_HASH_BUCKET_INDEX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EHBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ehbi_pkg.sv
// Shared types and constants for the ELF hash bucket index block.
package ehbi_pkg;

    localparam int HASH_W      = 28;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 16;
    localparam int INDEX_BITS  = 16;
    localparam int STEP_SHIFT  = 4;
    localparam int COUNT_W     = 16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1024;

    localparam logic [INDEX_W-1:0] IDX_MASK = (INDEX_BITS >= INDEX_W) ? {INDEX_W{1'b1}} :
        INDEX_W'((32'd1 << INDEX_BITS) - 32'd1);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam int DIV_CNT_W = $clog2(HASH_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(HASH_W - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [INDEX_W-1:0] bucket_index;
        logic [HASH_W-1:0]  raw_hash;
    } t_out_beat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_LOAD
    } t_back_state;

endpackage

FILE: src/ehbi_front.sv
// Front end: accepts key bytes, runs the ELF hash step and queues finished hashes.
module ehbi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ehbi_pkg::t_in_beat           i_in_data,
    input  ehbi_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output logic [ehbi_pkg::HASH_W-1:0]  o_push_hash
);
    import ehbi_pkg::*;

    logic [HASH_W-1:0]          r_hash;
    logic [HASH_W-1:0]          n_hash;
    logic [HASH_W+STEP_SHIFT-1:0] sum;
    logic [STEP_SHIFT-1:0]      top;
    logic [HASH_W-1:0]          stepped;
    logic                       accept;

    always_comb begin
        sum     = {r_hash, {STEP_SHIFT{1'b0}}} + {{(HASH_W+STEP_SHIFT-BYTE_W){1'b0}},
                                                   i_in_data.key_byte};
        top     = sum[HASH_W+STEP_SHIFT-1:HASH_W];
        stepped = sum[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, top, {STEP_SHIFT{1'b0}}};
    end

    assign o_in_stall  = i_q_status.full;
    assign accept      = i_in_valid && !i_q_status.full;
    assign o_push      = accept && i_in_data.last_byte;
    assign o_push_hash = stepped;

    always_comb begin
        n_hash = r_hash;
        if (accept) begin
            n_hash = i_in_data.last_byte ? '0 : stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

FILE: src/ehbi_queue.sv
// Short queue of finished hashes between the front and back ends.
module ehbi_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [ehbi_pkg::HASH_W-1:0]  i_push_hash,
    input  logic                         i_pop,
    output logic [ehbi_pkg::HASH_W-1:0]  o_head_hash,
    output ehbi_pkg::t_q_status          o_status
);
    import ehbi_pkg::*;

    logic [HASH_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head_hash    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/ehbi_back.sv
// Back end: bit-serial modulo of each queued hash and the output register.
`include "elf_hash_bucket_index_defines.svh"

module ehbi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ehbi_pkg::COUNT_W-1:0]  i_bucket_count,
    input  ehbi_pkg::t_q_status           i_q_status,
    input  logic [ehbi_pkg::HASH_W-1:0]   i_head_hash,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ehbi_pkg::t_out_beat           o_out_data
);
    import ehbi_pkg::*;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [HASH_W-1:0]    r_dividend;
    logic [HASH_W-1:0]    r_hash;
    logic [COUNT_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_count;
    logic                 r_out_valid;
    t_out_beat            r_out;
    logic                 out_free;
    logic                 load_out;
    logic [COUNT_W:0]     trial;
    logic                 fits;
    logic [INDEX_W-1:0]   index;

    assign out_free = !r_out_valid || !i_out_stall;
    assign trial    = {r_rem, r_dividend[HASH_W-1]};
    assign fits     = (trial >= {1'b0, i_bucket_count});
    assign index    = (i_bucket_count == '0) ? r_hash[INDEX_W-1:0] : r_rem;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_count == DIV_LAST) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dividend <= i_head_hash;
            r_hash     <= i_head_hash;
            r_rem      <= '0;
            r_count    <= '0;
        end else if (r_state == S_RUN) begin
            r_dividend <= {r_dividend[HASH_W-2:0], 1'b0};
            r_rem      <= fits ? COUNT_W'(trial - {1'b0, i_bucket_count}) : trial[COUNT_W-1:0];
            r_count    <= r_count + 1'b1;
        end
        if (load_out) begin
            r_out.bucket_index <= index & IDX_MASK;
            r_out.raw_hash     <= r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `EHBI_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, o_pop, !i_q_status.empty, "pop from empty queue")
    `EHBI_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, load_out, r_out_valid, "loaded beat not valid")
    `EHBI_ASSERT_NEXT(a_run_follows_pop, i_clk, i_rst_n, o_pop, (r_state == S_RUN) && (r_count == '0), "divide did not start")

endmodule

FILE: src/elf_hash_bucket_index.sv
// Top level of the ELF hash bucket index block.
// Key bytes arrive one beat per cycle, while o_in_stall is low, on the input channel
// (i_in_valid, o_in_stall, i_in_data); last_byte marks the final byte of a key. The
// front end folds each byte into the running hash in the cycle it is accepted, so bytes
// stream at one per cycle until the queue fills. On the last byte the finished hash goes
// into a four-entry queue and the running hash returns to zero for the next key.
// The back end takes one hash at a time from the queue and forms the remainder by the
// bucket count with a restoring divider, one quotient bit per cycle, from the top bit down.
// It pops a hash, runs the divide and loads the output register before it pops the next.
// A zero bucket count returns the low bits of the hash as the index.
// The output register holds a beat while i_out_stall is high; the divider then waits
// with its result, the queue fills, and o_in_stall rises only once the queue is full.
// Reset is synchronous and active low: the running hash is cleared, the queue emptied,
// the output invalidated and the bucket count set to 1024. Write the bucket count with
// i_cfg_we and i_cfg_data only while no key is in flight.
module elf_hash_bucket_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ehbi_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ehbi_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ehbi_pkg::t_out_beat           o_out_data
);
    import ehbi_pkg::*;

    logic [COUNT_W-1:0] r_bucket_count;
    t_q_status          q_status;
    logic               push;
    logic [HASH_W-1:0]  push_hash;
    logic               pop;
    logic [HASH_W-1:0]  head_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    ehbi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_hash (push_hash)
    );

    ehbi_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_hash (push_hash),
        .i_pop       (pop),
        .o_head_hash (head_hash),
        .o_status    (q_status)
    );

    ehbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_q_status     (q_status),
        .i_head_hash    (head_hash),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
